>>> design/tdr_pkg.sv
// ----------------------------------------------------------------------------
// tdr_pkg: shared types and constants for the turtle dead reckoning block
// Fixed widths of the datapath, command codes, the sequencer state type and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tdr_pkg;

	// Port payload widths.
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;
	localparam int AMT_W    = 16;

	// Position, CORDIC and multiplier widths.
	localparam int POS_W   = 48;
	localparam int TRIG_W  = 34;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = TRIG_W + MUL_B_W;
	localparam int STEP_W  = PROD_W + 1;

	// Distance root extraction widths.
	localparam int RAD_W  = 2 * POS_W;
	localparam int ROOT_W = POS_W;
	localparam int REM_W  = ROOT_W + 4;
	localparam int RCNT_W = $clog2(ROOT_W);

	// CORDIC constants in Q2.30.
	localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [TRIG_W-1:0] ONE_Q30  = 34'sd1073741824;
	localparam logic signed [TRIG_W-1:0] DEG_Q30  = 34'sd18740330;

	// Reciprocal of 360 scaled by 2^24, rounded up; exact for any 16-bit value.
	localparam logic signed [MUL_B_W-1:0] RECIP_360 = 25'sd46604;
	localparam int RECIP_SH = 24;

	// Turtle commands.
	typedef enum logic [1:0] {
		CMD_FD = 2'd0,
		CMD_BK = 2'd1,
		CMD_LT = 2'd2,
		CMD_RT = 2'd3
	} cmd_t;

	// Sequencer states, one-hot.
	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_ZMUL   = 15'h0002,
		S_ZLD    = 15'h0004,
		S_ROT    = 15'h0008,
		S_QUAD   = 15'h0010,
		S_MMUL   = 15'h0020,
		S_MACC   = 15'h0040,
		S_TMUL   = 15'h0080,
		S_TACC   = 15'h0100,
		S_ABS    = 15'h0200,
		S_SQMUL  = 15'h0400,
		S_SQACC  = 15'h0800,
		S_RSTART = 15'h1000,
		S_ROOT   = 15'h2000,
		S_OUT    = 15'h4000
	} state_t;

	// Rounded atan(2^-i) in Q2.30.
	function automatic logic signed [TRIG_W-1:0] tdr_atan(input logic [4:0] idx);
		logic signed [TRIG_W-1:0] v;
		case (idx)
			5'd0:  v = 34'sd843314857;
			5'd1:  v = 34'sd497837829;
			5'd2:  v = 34'sd263043837;
			5'd3:  v = 34'sd133525159;
			5'd4:  v = 34'sd67021687;
			5'd5:  v = 34'sd33543516;
			5'd6:  v = 34'sd16775851;
			5'd7:  v = 34'sd8388437;
			5'd8:  v = 34'sd4194283;
			5'd9:  v = 34'sd2097149;
			5'd10: v = 34'sd1048576;
			5'd11: v = 34'sd524288;
			5'd12: v = 34'sd262144;
			5'd13: v = 34'sd131072;
			5'd14: v = 34'sd65536;
			5'd15: v = 34'sd32768;
			5'd16: v = 34'sd16384;
			5'd17: v = 34'sd8192;
			5'd18: v = 34'sd4096;
			5'd19: v = 34'sd2048;
			5'd20: v = 34'sd1024;
			5'd21: v = 34'sd512;
			5'd22: v = 34'sd256;
			5'd23: v = 34'sd128;
			5'd24: v = 34'sd64;
			5'd25: v = 34'sd32;
			5'd26: v = 34'sd16;
			5'd27: v = 34'sd8;
			5'd28: v = 34'sd4;
			5'd29: v = 34'sd2;
			5'd30: v = 34'sd1;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

>>> design/tdr_isqrt.sv
// ----------------------------------------------------------------------------
// tdr_isqrt: bit-serial integer square root
// Restoring digit-by-digit root of the squared radius, one result bit per
// cycle. A start pulse loads the radicand; done pulses when the root is ready.
// ----------------------------------------------------------------------------
module tdr_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tdr_pkg::RAD_W-1:0]   radicand,
	output logic                        done,
	output logic [tdr_pkg::ROOT_W-1:0]  root
);
	import tdr_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [RCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              take;

	// Bring down the next two radicand bits and try 4*root+1.
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign take   = rem_sh >= trial;

	// Control: busy flag and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == RCNT_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: one root bit per cycle while busy.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
			cnt_q  <= cnt_q + RCNT_W'(1);
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> design/turtle_dead_reckoning.sv
// ----------------------------------------------------------------------------
// turtle_dead_reckoning: turtle command integrator with distance readout
// Tracks position and heading from forward, back, left and right commands and
// reports the rounded distance from the origin at the end of each sequence.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the s_ channel: tdata carries the command and a signed
// amount, tlast marks the final command of a sequence. The block takes one
// item at a time and holds s_tready low while it works on it.
// A turn keeps s_tready low for one pass through the shared multiplier. A
// move keeps it low while the rotation-mode CORDIC loop runs one iteration
// per cycle and the multiplier then scales x and y in turn; a heading on a
// multiple of 90 degrees skips the loop. s_tready rises again as the block
// returns to idle. An item with tlast adds six multiplier passes that square
// the position, then the root unit produces one bit per cycle. The distance
// then appears on the m_ channel and position and heading clear.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls, a following last item waits for the
// register to empty before its result is written.
// Reset clears position, heading and the output valid flag; s_tready is high
// during reset and from the first clock edge after its release.
// ----------------------------------------------------------------------------
module turtle_dead_reckoning #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_ITERS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tdr_pkg::S_DATA_W-1:0]   s_tdata,   // cmd[1:0], amount[17:2], zero pad
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tdr_pkg::M_DATA_W-1:0]   m_tdata    // distance[31:0]
);
	import tdr_pkg::*;

	localparam int IT_W  = $clog2(CORDIC_ITERS);
	localparam int SCL_SH = 30 - FRAC_BITS;
	localparam logic signed [STEP_W-1:0] STEP_RND = STEP_W'(1) <<< (SCL_SH - 1);

	// Architectural state and control.
	state_t                   state_q, state_d;
	logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
	logic [8:0]               heading_q;
	logic                     m_valid_q;
	logic [M_DATA_W-1:0]      dist_q;

	// Item and working registers.
	cmd_t                     cmd_q;
	logic signed [AMT_W-1:0]  amt_q;
	logic                     last_q;
	logic [1:0]               quad_q;
	logic [6:0]               rem_deg_q;
	logic signed [TRIG_W-1:0] x_q, y_q, z_q;
	logic [IT_W-1:0]          it_q;
	logic                     axis_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [POS_W-1:0]         ax_q, ay_q;
	logic [RAD_W-1:0]         acc_q;
	logic [2:0]               k_q;

	logic                     accept;
	logic signed [TRIG_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [16:0]       mv_d;
	logic [AMT_W-1:0]         amt_abs;

	logic                     sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]        sqrt_root;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = dist_q;

	// Signed move distance and unsigned turn magnitude.
	always_comb begin
		mv_d = {amt_q[AMT_W-1], amt_q};
		if (cmd_q == CMD_BK) begin
			mv_d = -mv_d;
		end
		amt_abs = amt_q[AMT_W-1] ? AMT_W'(-amt_q) : AMT_W'(amt_q);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ZMUL: begin
				mul_a = DEG_Q30;
				mul_b = MUL_B_W'(rem_deg_q);
			end
			S_MMUL: begin
				mul_a = axis_q ? y_q : x_q;
				mul_b = MUL_B_W'(mv_d);
			end
			S_TMUL: begin
				mul_a = TRIG_W'(amt_abs);
				mul_b = RECIP_360;
			end
			S_SQMUL: begin
				unique case (k_q)
					3'd0: begin
						mul_a = TRIG_W'(ax_q[23:0]);
						mul_b = MUL_B_W'(ax_q[23:0]);
					end
					3'd1: begin
						mul_a = TRIG_W'(ax_q[23:0]);
						mul_b = MUL_B_W'(ax_q[47:24]);
					end
					3'd2: begin
						mul_a = TRIG_W'(ax_q[47:24]);
						mul_b = MUL_B_W'(ax_q[47:24]);
					end
					3'd3: begin
						mul_a = TRIG_W'(ay_q[23:0]);
						mul_b = MUL_B_W'(ay_q[23:0]);
					end
					3'd4: begin
						mul_a = TRIG_W'(ay_q[23:0]);
						mul_b = MUL_B_W'(ay_q[47:24]);
					end
					3'd5: begin
						mul_a = TRIG_W'(ay_q[47:24]);
						mul_b = MUL_B_W'(ay_q[47:24]);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			S_IDLE, S_ZLD, S_ROT, S_QUAD, S_MACC, S_TACC, S_ABS, S_SQACC,
			S_RSTART, S_ROOT, S_OUT: begin
				mul_a = '0;
				mul_b = '0;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (cmd_t'(s_tdata[1:0]) == CMD_FD ||
						cmd_t'(s_tdata[1:0]) == CMD_BK) ? S_ZMUL : S_TMUL;
				end
			end
			S_ZMUL:   state_d = S_ZLD;
			S_ZLD:    state_d = (rem_deg_q == 7'd0) ? S_QUAD : S_ROT;
			S_ROT:    state_d = (it_q == IT_W'(CORDIC_ITERS - 1)) ? S_QUAD : S_ROT;
			S_QUAD:   state_d = S_MMUL;
			S_MMUL:   state_d = S_MACC;
			S_MACC: begin
				if (!axis_q) begin
					state_d = S_MMUL;
				end else begin
					state_d = last_q ? S_ABS : S_IDLE;
				end
			end
			S_TMUL:   state_d = S_TACC;
			S_TACC:   state_d = last_q ? S_ABS : S_IDLE;
			S_ABS:    state_d = S_SQMUL;
			S_SQMUL:  state_d = S_SQACC;
			S_SQACC:  state_d = (k_q == 3'd5) ? S_RSTART : S_SQMUL;
			S_RSTART: state_d = S_ROOT;
			S_ROOT:   state_d = sqrt_done ? S_OUT : S_ROOT;
			S_OUT:    state_d = (!m_valid_q || m_tready) ? S_IDLE : S_OUT;
			default:  state_d = S_IDLE;
		endcase
	end

	assign sqrt_start = state_q == S_RSTART;

	// Move step: round the scaled product, add and saturate.
	logic signed [STEP_W-1:0] step_v, pos_sum;
	logic signed [POS_W-1:0]  pos_sel, pos_new;
	always_comb begin
		step_v  = (STEP_W'(prod_q) + STEP_RND) >>> SCL_SH;
		pos_sel = axis_q ? pos_y_q : pos_x_q;
		pos_sum = STEP_W'(pos_sel) + step_v;
		if (pos_sum[STEP_W-1:POS_W-1] == '0 || pos_sum[STEP_W-1:POS_W-1] == '1) begin
			pos_new = pos_sum[POS_W-1:0];
		end else begin
			pos_new = pos_sum[STEP_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
				: {1'b0, {(POS_W-1){1'b1}}};
		end
	end

	// Turn: remainder of the magnitude by 360, signed, added to the heading.
	logic [6:0]  t_quo;
	logic [15:0] t_q360;
	logic [16:0] t_rem17;
	logic [8:0]  t_rem, t_add;
	logic [9:0]  h_sum;
	logic [8:0]  h_new;
	logic        t_neg;
	always_comb begin
		t_quo   = prod_q[RECIP_SH +: 7];
		t_q360  = 16'(t_quo) * 16'd360;
		t_rem17 = 17'(amt_abs) - 17'(t_q360);
		if (t_rem17 >= 17'd360) begin
			t_rem17 = t_rem17 - 17'd360;
		end
		t_rem = t_rem17[8:0];
		t_neg = amt_q[AMT_W-1] ^ (cmd_q == CMD_RT);
		if (!t_neg) begin
			t_add = t_rem;
		end else if (t_rem == 9'd0) begin
			t_add = 9'd0;
		end else begin
			t_add = 9'd360 - t_rem;
		end
		h_sum = 10'(heading_q) + 10'(t_add);
		if (h_sum >= 10'd360) begin
			h_sum = h_sum - 10'd360;
		end
		h_new = h_sum[8:0];
	end

	// Rounded, saturated distance from the root.
	logic [ROOT_W:0]     dist_full;
	logic [M_DATA_W-1:0] dist_v;
	always_comb begin
		dist_full = ({1'b0, sqrt_root} + ((ROOT_W + 1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		dist_v    = (|dist_full[ROOT_W:M_DATA_W]) ? '1 : dist_full[M_DATA_W-1:0];
	end

	// Control registers, position and heading.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			heading_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			priority if (state_q == S_MACC) begin
				if (axis_q) begin
					pos_y_q <= pos_new;
				end else begin
					pos_x_q <= pos_new;
				end
			end else if (state_q == S_TACC) begin
				heading_q <= h_new;
			end else if (state_q == S_OUT && (!m_valid_q || m_tready)) begin
				pos_x_q   <= '0;
				pos_y_q   <= '0;
				heading_q <= '0;
			end
		end
	end

	// Working registers of the sequencer.
	logic signed [TRIG_W-1:0] rot_dx, rot_dy, rot_atan;
	assign rot_dx   = y_q >>> it_q;
	assign rot_dy   = x_q >>> it_q;
	assign rot_atan = tdr_atan(5'(it_q));

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q  <= cmd_t'(s_tdata[1:0]);
					amt_q  <= s_tdata[17:2];
					last_q <= s_tlast;
					priority if (heading_q >= 9'd270) begin
						quad_q    <= 2'd3;
						rem_deg_q <= 7'(heading_q - 9'd270);
					end else if (heading_q >= 9'd180) begin
						quad_q    <= 2'd2;
						rem_deg_q <= 7'(heading_q - 9'd180);
					end else if (heading_q >= 9'd90) begin
						quad_q    <= 2'd1;
						rem_deg_q <= 7'(heading_q - 9'd90);
					end else begin
						quad_q    <= 2'd0;
						rem_deg_q <= heading_q[6:0];
					end
				end
			end
			S_ZMUL, S_MMUL, S_TMUL, S_SQMUL: begin
				prod_q <= mul_a * mul_b;
			end
			S_ZLD: begin
				z_q  <= prod_q[TRIG_W-1:0];
				x_q  <= (rem_deg_q == 7'd0) ? ONE_Q30 : GAIN_Q30;
				y_q  <= '0;
				it_q <= '0;
			end
			S_ROT: begin
				if (!z_q[TRIG_W-1]) begin
					x_q <= x_q - rot_dx;
					y_q <= y_q + rot_dy;
					z_q <= z_q - rot_atan;
				end else begin
					x_q <= x_q + rot_dx;
					y_q <= y_q - rot_dy;
					z_q <= z_q + rot_atan;
				end
				it_q <= it_q + IT_W'(1);
			end
			S_QUAD: begin
				unique case (quad_q)
					2'd1: begin
						x_q <= -y_q;
						y_q <= x_q;
					end
					2'd2: begin
						x_q <= -x_q;
						y_q <= -y_q;
					end
					2'd3: begin
						x_q <= y_q;
						y_q <= -x_q;
					end
					default: begin
						x_q <= x_q;
						y_q <= y_q;
					end
				endcase
				axis_q <= 1'b0;
			end
			S_MACC: begin
				axis_q <= 1'b1;
			end
			S_ABS: begin
				ax_q  <= pos_x_q[POS_W-1] ? POS_W'(-pos_x_q) : POS_W'(pos_x_q);
				ay_q  <= pos_y_q[POS_W-1] ? POS_W'(-pos_y_q) : POS_W'(pos_y_q);
				acc_q <= '0;
				k_q   <= '0;
			end
			S_SQACC: begin
				unique case (k_q)
					3'd1, 3'd4: acc_q <= acc_q + (RAD_W'(prod_q[47:0]) << 25);
					3'd2, 3'd5: acc_q <= acc_q + (RAD_W'(prod_q[47:0]) << 48);
					default:    acc_q <= acc_q + RAD_W'(prod_q[47:0]);
				endcase
				k_q <= k_q + 3'd1;
			end
			S_OUT: begin
				if (!m_valid_q || m_tready) begin
					dist_q <= dist_v;
				end
			end
			S_TACC, S_RSTART, S_ROOT: begin
				axis_q <= axis_q;
			end
			default: begin
				axis_q <= axis_q;
			end
		endcase
	end

	// Square root of the squared radius.
	tdr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

endmodule

>>> design/tdr_checker.sv
// ----------------------------------------------------------------------------
// tdr_checker: port-level checks for the turtle dead reckoning block
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tdr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tdr_pkg::M_DATA_W-1:0]  m_tdata
);
	import tdr_pkg::*;

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	// A stalled result item holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("ready stayed high after an item was accepted");

	// An item without tlast never produces a result right away.
	a_no_result_mid_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !s_tlast && !m_tvalid |=> !m_tvalid)
		else $error("result item appeared after a non-final item");

	// A result is posted as the block returns to idle.
	a_result_with_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result item appeared while the block was busy");

endmodule

bind turtle_dead_reckoning tdr_checker u_tdr_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the turtle dead reckoning block
// Drives turtle commands on the input stream and checks every distance on the
// output stream against a bit-accurate tracker of position and heading. A
// table of directed commands covers the extremes, every command and the turn
// wrap cases. Two straight runs at full speed build a large position on both
// axes. Random command sequences follow, with random idling on both sides and
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
	import tdr_pkg::*;

	localparam int FRAC  = 16;
	localparam int ITERS = 24;

	// Fixed-point constants of the tracker, Q2.30.
	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam longint UNIT_Q30    = 64'sd1073741824;
	localparam longint RAD_PER_DEG = 64'sd18740330;
	localparam longint POS_HI      = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint POS_LO      = -POS_HI - 64'sd1;

	localparam longint ATAN_TAB [0:31] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
		64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
		64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
		64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768,
		64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048,
		64'sd1024, 64'sd512, 64'sd256, 64'sd128,
		64'sd64, 64'sd32, 64'sd16, 64'sd8,
		64'sd4, 64'sd2, 64'sd1, 64'sd0
	};

	localparam int RANDOM_ITEMS = 2000;
	localparam int RAIL_MOVES   = 64;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AFTER   = 40;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int PLAN_ROWS    = 25;

	typedef struct packed {
		cmd_t               op;
		logic signed [15:0] amt;
		logic               fin;
		logic               known;
		logic [31:0]        want;
	} plan_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	// Tracker state: position in fixed point and heading in whole degrees.
	longint      trk_x;
	longint      trk_y;
	int          trk_heading;

	logic [31:0] dist_due [$];
	logic [31:0] dist_want;
	int          dist_got;
	int          fails;
	int          cycle_cnt;
	bit          steady;
	bit          held;
	plan_row_t   plan [0:PLAN_ROWS-1];

	turtle_dead_reckoning #(
		.FRAC_BITS    (FRAC),
		.CORDIC_ITERS (ITERS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Cosine and sine of a heading in Q2.30, quadrant reduced.
	function automatic void heading_trig(input int h, output longint cs, output longint sn);
		int     q;
		int     r;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		q = (h / 90) % 4;
		r = h % 90;
		x = CORDIC_GAIN;
		y = 64'sd0;
		z = longint'(r) * RAD_PER_DEG;
		if (r == 0) begin
			x = UNIT_Q30;
			y = 64'sd0;
		end else begin
			for (int i = 0; i < ITERS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_TAB[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_TAB[i];
				end
			end
		end
		case (q)
			1: begin
				cs = -y;
				sn = x;
			end
			2: begin
				cs = -x;
				sn = -y;
			end
			3: begin
				cs = y;
				sn = -x;
			end
			default: begin
				cs = x;
				sn = y;
			end
		endcase
	endfunction

	// Scale a distance-times-trig product down to position units, rounding half up.
	function automatic longint move_step(input longint prod);
		return (prod + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
	endfunction

	function automatic longint clamp_pos(input longint v);
		if (v > POS_HI)
			return POS_HI;
		if (v < POS_LO)
			return POS_LO;
		return v;
	endfunction

	// Rounded Euclidean distance from the origin, exact integer square root.
	function automatic logic [31:0] origin_distance(input longint px, input longint py);
		logic [63:0]  ax;
		logic [63:0]  ay;
		logic [127:0] sq;
		logic [63:0]  root;
		logic [63:0]  cand;
		logic [63:0]  rnd;
		ax = (px < 0) ? 64'(-px) : 64'(px);
		ay = (py < 0) ? 64'(-py) : 64'(py);
		sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
		root = 64'd0;
		for (int b = 49; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (128'(cand) * 128'(cand) <= sq)
				root = cand;
		end
		rnd = (root + (64'd1 << (FRAC - 1))) >> FRAC;
		return (rnd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rnd[31:0];
	endfunction

	// Apply one command to the tracker; returns 1 when it yields a distance.
	function automatic bit track_command(input cmd_t op, input logic signed [15:0] amt,
			input logic fin, output logic [31:0] dist_out);
		longint d;
		longint cs;
		longint sn;
		int     turn;
		if (op == CMD_FD || op == CMD_BK) begin
			d = (op == CMD_FD) ? longint'(amt) : -longint'(amt);
			heading_trig(trk_heading, cs, sn);
			trk_x = clamp_pos(trk_x + move_step(d * cs));
			trk_y = clamp_pos(trk_y + move_step(d * sn));
		end else begin
			turn = int'(amt) % 360;
			if (op == CMD_RT)
				turn = -turn;
			trk_heading = (trk_heading + turn + 360) % 360;
		end
		dist_out = 32'd0;
		if (!fin)
			return 1'b0;
		dist_out = origin_distance(trk_x, trk_y);
		trk_x = 64'sd0;
		trk_y = 64'sd0;
		trk_heading = 0;
		return 1'b1;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 90);
	endfunction

	function automatic logic signed [15:0] pick_amount();
		case ($urandom_range(0, 7))
			0, 1: return 16'($urandom);
			2: begin
				case ($urandom_range(0, 4))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			3: return 16'(($urandom_range(0, 8) - 4) * 90);
			default: return 16'($urandom_range(0, 800) - 400);
		endcase
	endfunction

	// Offer one item after an optional gap and hold it until it is taken.
	task automatic send_command(input cmd_t op, input logic signed [15:0] amt, input logic fin,
			input int gap, input logic known, input logic [31:0] want);
		logic [31:0] dist_val;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, amt, op};
		s_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		if (track_command(op, amt, fin, dist_val))
			dist_due.push_back(known ? want : dist_val);
	endtask

	// Cycle limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Distance checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			dist_got = dist_got + 1;
			if (dist_due.size() == 0) begin
				$error("distance: no item expected, got %0d", m_tdata);
				fails = fails + 1;
			end else begin
				dist_want = dist_due.pop_front();
				if (m_tdata !== dist_want) begin
					$error("distance: expected %0d, got %0d", dist_want, m_tdata);
					fails = fails + 1;
				end
			end
		end
	end

	// Receiver: random ready pattern, with one long hold-off once results flow.
	initial begin
		int k;
		m_tready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (!held && dist_got >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				k = idle_len();
				m_tready <= 1'b0;
				repeat ((k < 1) ? 1 : k) @(posedge clk);
			end
		end
	end

	// Main stimulus.
	initial begin
		int   sent;
		int   run_len;
		cmd_t op;
		trk_x       = 64'sd0;
		trk_y       = 64'sd0;
		trk_heading = 0;
		dist_got    = 0;
		fails       = 0;
		cycle_cnt   = 0;
		steady      = 1'b0;
		held        = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;

		// Directed commands; a typed distance only where it is obvious.
		plan = '{
			'{CMD_FD, 16'sd0,      1'b1, 1'b1, 32'd0},     // zero move right after reset
			'{CMD_FD, 16'sh7FFF,   1'b1, 1'b1, 32'd32767},
			'{CMD_BK, 16'sh8000,   1'b1, 1'b1, 32'd32768}, // back by the most negative amount
			'{CMD_FD, 16'sh8000,   1'b1, 1'b1, 32'd32768},
			'{CMD_LT, 16'sd90,     1'b0, 1'b0, 32'd0},
			'{CMD_FD, 16'sd100,    1'b1, 1'b1, 32'd100},
			'{CMD_RT, 16'sd90,     1'b0, 1'b0, 32'd0},     // heading wraps to 270
			'{CMD_BK, 16'sd5,      1'b1, 1'b1, 32'd5},
			'{CMD_LT, 16'sd180,    1'b0, 1'b0, 32'd0},
			'{CMD_FD, 16'sd7,      1'b1, 1'b1, 32'd7},
			'{CMD_LT, 16'sh7FFF,   1'b0, 1'b0, 32'd0},     // largest left turn, 7 degrees net
			'{CMD_FD, 16'sd1000,   1'b0, 1'b0, 32'd0},
			'{CMD_LT, 16'sh8000,   1'b0, 1'b0, 32'd0},     // negative left turn acts as right
			'{CMD_FD, 16'sd12345,  1'b1, 1'b0, 32'd0},
			'{CMD_RT, 16'sd45,     1'b0, 1'b0, 32'd0},
			'{CMD_FD, 16'sd1234,   1'b0, 1'b0, 32'd0},
			'{CMD_LT, 16'sd0,      1'b0, 1'b0, 32'd0},
			'{CMD_FD, 16'sd0,      1'b0, 1'b0, 32'd0},
			'{CMD_BK, 16'sd777,    1'b1, 1'b0, 32'd0},
			'{CMD_RT, 16'sh8000,   1'b0, 1'b0, 32'd0},
			'{CMD_LT, 16'sd360,    1'b0, 1'b0, 32'd0},     // full circle leaves heading alone
			'{CMD_FD, -16'sd1,     1'b0, 1'b0, 32'd0},
			'{CMD_RT, 16'sh7FFF,   1'b0, 1'b0, 32'd0},
			'{CMD_BK, 16'sh7FFF,   1'b1, 1'b0, 32'd0},
			'{CMD_LT, 16'sd1,      1'b1, 1'b1, 32'd0}      // a turn alone ends at the origin
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++)
			send_command(plan[i].op, plan[i].amt, plan[i].fin, idle_len(),
				plan[i].known, plan[i].want);

		// Straight runs at full speed: far out along x, then along y after a left turn.
		steady = 1'b1;
		for (int i = 0; i < RAIL_MOVES; i++)
			send_command(CMD_BK, 16'sh8000, 1'b0, 0, 1'b0, 32'd0);
		send_command(CMD_LT, 16'sd90, 1'b0, 0, 1'b0, 32'd0);
		for (int i = 0; i < RAIL_MOVES; i++)
			send_command(CMD_FD, 16'sh8000, i == RAIL_MOVES - 1, 0, 1'b0, 32'd0);
		steady = 1'b0;

		// Random sequences, each closed by a last item.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady  = ($urandom_range(0, 7) == 0);
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
			for (int j = 0; j < run_len; j++) begin
				op = cmd_t'(2'($urandom_range(0, 3)));
				send_command(op, pick_amount(), j == run_len - 1, steady ? 0 : idle_len(),
					1'b0, 32'd0);
				sent = sent + 1;
			end
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		while (dist_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
